// ----- src/fbrs_pkg.sv -----
package fbrs_pkg;

  typedef logic [7:0] level_t;

  typedef enum logic [2:0] {
    RAMP_KICK   = 3'd0,
    RAMP_SETTLE = 3'd1,
    RAMP_UP     = 3'd2,
    RAMP_HIGH   = 3'd3,
    RAMP_DOWN   = 3'd4,
    RAMP_LOW    = 3'd5
  } ramp_phase_t;

  typedef enum logic [1:0] {
    DFL_IDLE   = 2'd0,
    DFL_ACTIVE = 2'd1,
    DFL_PEAK   = 2'd2
  } dfl_phase_t;

  typedef struct packed {
    logic        write_valid;
    level_t      drive_level;
    ramp_phase_t ramp_phase_now;
    dfl_phase_t  deflate_phase_now;
    logic        last;
  } res_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WAIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DFL_LEVEL      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DFL_HOLD_LEVEL = 3'd7;

  localparam logic [15:0] RST_RAMP_STEP_MS = 16'd20;
  localparam logic [15:0] RST_WAIT_MS      = 16'd1000;
  localparam level_t      RST_HIGH_LEVEL   = 8'd200;
  localparam level_t      RST_LOW_LEVEL    = 8'd50;

  localparam level_t KICK_LEVEL = 8'd230;
  localparam level_t PEAK_LEVEL = 8'd250;
  localparam level_t LEVEL_MAX  = 8'd255;
  localparam level_t LEVEL_MIN  = 8'd0;

  localparam logic [15:0] SETTLE_MS = 16'd200;
  localparam logic [15:0] PEAK_MS   = 16'd15000;
  localparam logic [15:0] HOLD_MS   = 16'd15200;

endpackage

// ----- src/fbrs_in_if.sv -----
interface fbrs_in_if #(parameter int TIME_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TIME_BITS-1:0] now_ms;

  modport source(output valid, req_type, now_ms, input ready);
  modport sink(input valid, req_type, now_ms, output ready);
endinterface

// ----- src/fbrs_out_if.sv -----
interface fbrs_out_if;
  logic                 valid;
  logic                 ready;
  logic                 write_valid;
  fbrs_pkg::level_t     drive_level;
  logic [2:0]           ramp_phase_now;
  logic [1:0]           deflate_phase_now;
  logic                 last;

  modport source(output valid, write_valid, drive_level, ramp_phase_now,
                 deflate_phase_now, last, input ready);
  modport sink(input valid, write_valid, drive_level, ramp_phase_now,
               deflate_phase_now, last, output ready);
endinterface

// ----- src/fan_breathe_ramp_sequencer.sv -----
// Fan breathe / deflate level sequencer.
// in_ch carries one evaluation step per request: req_type (0 breathe, 1 deflate)
// and the free-running millisecond time now_ms. out_ch returns the level writes
// the step causes: one result for a breathe step, one or two for a deflate step
// (two when the peak and hold levels fall due together); last marks the final one.
// A result with write_valid low means the step wrote nothing.
// Timing: a request is registered, evaluated in one pass of compares and an
// 8-bit increment or decrement, and its results are then loaded into the
// output register, from which the first result is offered on out_ch.
// Throughput is one request per cycle while every request gives one result
// and out_ch takes each one; a request that gives two results holds the input
// until its first result is taken, as the output register drains one per cycle.
// When out_ch stalls, the held result stays put and one further request is
// still taken into the input register; in_ch.ready drops only after that.
// Reset (rst_n low, synchronous) clears both sequencers to their start phase,
// the level and time marks to zero, and loads the registers with their defaults.
// cfg_we writes cfg_wdata into register cfg_index; write only when
// the block has no request in flight.
module fan_breathe_ramp_sequencer #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  fbrs_in_if.sink                             in_ch,
  fbrs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fbrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbrs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration
  logic [15:0]      up_step_r, down_step_r, high_wait_r, low_wait_r;
  fbrs_pkg::level_t high_level_r, low_level_r, dfl_level_r, dfl_hold_r;

  // sequencer state
  fbrs_pkg::ramp_phase_t ramp_phase_r, ramp_phase_nxt;
  fbrs_pkg::level_t      ramp_level_r, ramp_level_nxt;
  logic [TIME_BITS-1:0]  ramp_mark_r, ramp_mark_nxt;
  fbrs_pkg::dfl_phase_t  dfl_phase_r, dfl_phase_nxt;
  logic [TIME_BITS-1:0]  dfl_mark_r, dfl_mark_nxt;
  logic                  dfl_latched_r, dfl_latched_nxt;

  // input register
  logic                 stg_valid_r;
  logic                 stg_req_r;
  logic [TIME_BITS-1:0] stg_now_r;

  // result register, up to two results
  fbrs_pkg::res_t res0_r, res1_r, res0_nxt, res1_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  logic                 consume;
  logic [TIME_BITS-1:0] ramp_elapsed, dfl_elapsed;

  // ramp evaluation results
  logic             ramp_wr;
  fbrs_pkg::level_t ramp_wr_level;

  // deflate evaluation results
  logic dfl_fire_start, dfl_fire_peak, dfl_fire_hold;

  assign consume = stg_valid_r &&
                   ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready));
  assign in_ch.ready = !stg_valid_r || consume;

  assign ramp_elapsed = stg_now_r - ramp_mark_r;
  assign dfl_elapsed  = stg_now_r - dfl_mark_r;

  // breathe ramp next state; fresh means the mark was just set to now
  always_comb begin
    logic fresh;
    fresh          = 1'b0;
    ramp_phase_nxt = ramp_phase_r;
    ramp_level_nxt = ramp_level_r;
    ramp_wr        = 1'b0;
    ramp_wr_level  = fbrs_pkg::LEVEL_MIN;
    if (ramp_phase_nxt == fbrs_pkg::RAMP_KICK) begin
      fresh          = 1'b1;
      ramp_wr        = 1'b1;
      ramp_wr_level  = fbrs_pkg::KICK_LEVEL;
      ramp_phase_nxt = fbrs_pkg::RAMP_SETTLE;
    end
    if (ramp_phase_nxt == fbrs_pkg::RAMP_SETTLE && !fresh &&
        ramp_elapsed > TIME_BITS'(fbrs_pkg::SETTLE_MS)) begin
      ramp_phase_nxt = fbrs_pkg::RAMP_UP;
    end
    if (ramp_phase_nxt == fbrs_pkg::RAMP_UP) begin
      if (!fresh && ramp_elapsed > TIME_BITS'(up_step_r)) begin
        fresh         = 1'b1;
        ramp_wr       = 1'b1;
        ramp_wr_level = ramp_level_nxt;
        if (ramp_level_nxt != fbrs_pkg::LEVEL_MAX) begin
          ramp_level_nxt = ramp_level_nxt + 8'd1;
        end
      end
      if (ramp_level_nxt >= high_level_r) begin
        fresh          = 1'b1;
        ramp_phase_nxt = fbrs_pkg::RAMP_HIGH;
      end
    end
    if (ramp_phase_nxt == fbrs_pkg::RAMP_HIGH && !fresh &&
        ramp_elapsed > TIME_BITS'(high_wait_r)) begin
      ramp_phase_nxt = fbrs_pkg::RAMP_DOWN;
    end
    if (ramp_phase_nxt == fbrs_pkg::RAMP_DOWN) begin
      if (!fresh && ramp_elapsed > TIME_BITS'(down_step_r)) begin
        fresh         = 1'b1;
        ramp_wr       = 1'b1;
        ramp_wr_level = ramp_level_nxt;
        if (ramp_level_nxt != fbrs_pkg::LEVEL_MIN) begin
          ramp_level_nxt = ramp_level_nxt - 8'd1;
        end
      end
      if (ramp_level_nxt <= low_level_r) begin
        fresh          = 1'b1;
        ramp_phase_nxt = fbrs_pkg::RAMP_LOW;
      end
    end
    if (ramp_phase_nxt == fbrs_pkg::RAMP_LOW && !fresh &&
        ramp_elapsed > TIME_BITS'(low_wait_r)) begin
      ramp_phase_nxt = fbrs_pkg::RAMP_KICK;
    end
    ramp_mark_nxt = fresh ? stg_now_r : ramp_mark_r;
  end

  // deflate next state; peak and hold can both fall due in one step
  always_comb begin
    dfl_fire_start  = (dfl_phase_r == fbrs_pkg::DFL_IDLE) && !dfl_latched_r;
    dfl_fire_peak   = (dfl_phase_r == fbrs_pkg::DFL_ACTIVE) &&
                      (dfl_elapsed > TIME_BITS'(fbrs_pkg::PEAK_MS));
    dfl_fire_hold   = ((dfl_phase_r == fbrs_pkg::DFL_PEAK) || dfl_fire_peak) &&
                      (dfl_elapsed > TIME_BITS'(fbrs_pkg::HOLD_MS));
    dfl_phase_nxt   = dfl_phase_r;
    dfl_latched_nxt = dfl_latched_r | dfl_fire_start;
    dfl_mark_nxt    = dfl_fire_start ? stg_now_r : dfl_mark_r;
    if (dfl_fire_start) begin
      dfl_phase_nxt = fbrs_pkg::DFL_ACTIVE;
    end else if (dfl_fire_hold) begin
      dfl_phase_nxt = fbrs_pkg::DFL_IDLE;
    end else if (dfl_fire_peak) begin
      dfl_phase_nxt = fbrs_pkg::DFL_PEAK;
    end
  end

  // result assembly
  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    cnt_nxt  = cnt_r;
    if (consume) begin
      res1_nxt = '{write_valid: 1'b1, drive_level: dfl_hold_r,
                   ramp_phase_now: ramp_phase_r,
                   deflate_phase_now: fbrs_pkg::DFL_IDLE, last: 1'b1};
      cnt_nxt  = 2'd1;
      if (!stg_req_r) begin
        res0_nxt = '{write_valid: ramp_wr, drive_level: ramp_wr_level,
                     ramp_phase_now: ramp_phase_nxt,
                     deflate_phase_now: fbrs_pkg::DFL_IDLE, last: 1'b1};
      end else if (dfl_fire_start) begin
        res0_nxt = '{write_valid: 1'b1, drive_level: dfl_level_r,
                     ramp_phase_now: ramp_phase_r,
                     deflate_phase_now: fbrs_pkg::DFL_ACTIVE, last: 1'b1};
      end else if (dfl_fire_peak) begin
        res0_nxt = '{write_valid: 1'b1, drive_level: fbrs_pkg::PEAK_LEVEL,
                     ramp_phase_now: ramp_phase_r,
                     deflate_phase_now: fbrs_pkg::DFL_PEAK,
                     last: !dfl_fire_hold};
        if (dfl_fire_hold) begin
          cnt_nxt = 2'd2;
        end
      end else if (dfl_fire_hold) begin
        res0_nxt = res1_nxt;
      end else begin
        res0_nxt = '{write_valid: 1'b0, drive_level: fbrs_pkg::LEVEL_MIN,
                     ramp_phase_now: ramp_phase_r,
                     deflate_phase_now: dfl_phase_r, last: 1'b1};
      end
    end else if (out_ch.valid && out_ch.ready) begin
      if (cnt_r == 2'd2) begin
        res0_nxt = res1_r;
        cnt_nxt  = 2'd1;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
  end

  assign out_ch.valid             = (cnt_r != 2'd0);
  assign out_ch.write_valid       = res0_r.write_valid;
  assign out_ch.drive_level       = res0_r.drive_level;
  assign out_ch.ramp_phase_now    = res0_r.ramp_phase_now;
  assign out_ch.deflate_phase_now = res0_r.deflate_phase_now;
  assign out_ch.last              = res0_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_step_r    <= fbrs_pkg::RST_RAMP_STEP_MS;
      down_step_r  <= fbrs_pkg::RST_RAMP_STEP_MS;
      high_wait_r  <= fbrs_pkg::RST_WAIT_MS;
      low_wait_r   <= fbrs_pkg::RST_WAIT_MS;
      high_level_r <= fbrs_pkg::RST_HIGH_LEVEL;
      low_level_r  <= fbrs_pkg::RST_LOW_LEVEL;
      dfl_level_r  <= fbrs_pkg::LEVEL_MIN;
      dfl_hold_r   <= fbrs_pkg::LEVEL_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        fbrs_pkg::CFG_RAMP_UP_STEP:   up_step_r    <= cfg_wdata;
        fbrs_pkg::CFG_RAMP_DOWN_STEP: down_step_r  <= cfg_wdata;
        fbrs_pkg::CFG_HIGH_WAIT:      high_wait_r  <= cfg_wdata;
        fbrs_pkg::CFG_LOW_WAIT:       low_wait_r   <= cfg_wdata;
        fbrs_pkg::CFG_HIGH_LEVEL:     high_level_r <= cfg_wdata[7:0];
        fbrs_pkg::CFG_LOW_LEVEL:      low_level_r  <= cfg_wdata[7:0];
        fbrs_pkg::CFG_DFL_LEVEL:      dfl_level_r  <= cfg_wdata[7:0];
        fbrs_pkg::CFG_DFL_HOLD_LEVEL: dfl_hold_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r   <= 1'b0;
      cnt_r         <= 2'd0;
      ramp_phase_r  <= fbrs_pkg::RAMP_KICK;
      ramp_level_r  <= fbrs_pkg::LEVEL_MIN;
      ramp_mark_r   <= '0;
      dfl_phase_r   <= fbrs_pkg::DFL_IDLE;
      dfl_mark_r    <= '0;
      dfl_latched_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_ch.valid && in_ch.ready) begin
        stg_valid_r <= 1'b1;
      end else if (consume) begin
        stg_valid_r <= 1'b0;
      end
      if (consume) begin
        if (!stg_req_r) begin
          ramp_phase_r  <= ramp_phase_nxt;
          ramp_level_r  <= ramp_level_nxt;
          ramp_mark_r   <= ramp_mark_nxt;
          // a breathe step releases the deflate latch
          dfl_phase_r   <= fbrs_pkg::DFL_IDLE;
          dfl_latched_r <= 1'b0;
        end else begin
          dfl_phase_r   <= dfl_phase_nxt;
          dfl_mark_r    <= dfl_mark_nxt;
          dfl_latched_r <= dfl_latched_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_req_r <= in_ch.req_type;
      stg_now_r <= in_ch.now_ms;
    end
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

`ifndef NO_ASSERTIONS
  a_breathe_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    consume && !stg_req_r |=> cnt_r == 2'd1)
    else $error("breathe request did not load exactly one result");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> res0_r.write_valid && !res0_r.last && res1_r.last)
    else $error("result pair out of order");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> res0_r.last)
    else $error("lone pending result not marked last");

  a_deflate_keeps_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    consume && stg_req_r |=> $stable(ramp_level_r) && $stable(ramp_phase_r)
      && dfl_latched_r)
    else $error("deflate request disturbed ramp state or left latch clear");
`endif

endmodule
